### hw/rtl/pprm_pkg.sv
package pprm_pkg;

  // Field and register widths
  localparam int TIME_W     = 32;
  localparam int RPM_W      = 16;
  localparam int PPR_W      = 8;
  localparam int TIMEOUT_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Revolutions-per-minute numerator: milliseconds in one minute
  localparam logic [RPM_W-1:0] RPM_NUMERATOR = 16'd60000;

  // Register reset values
  localparam logic [PPR_W-1:0]     PPR_RESET     = 8'd2;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd300;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PPR     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;

  // Item kinds
  localparam logic KIND_CHANGE = 1'b0;
  localparam logic KIND_POLL   = 1'b1;

  // Request to the shared divider: dividend is the quotient width
  typedef struct packed {
    logic              start;
    logic [RPM_W-1:0]  dividend;
    logic [TIME_W-1:0] divisor;
  } div_req_t;

endpackage

### hw/rtl/pprm_in_if.sv
interface pprm_in_if;
  import pprm_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic              pin_level;
  logic [TIME_W-1:0] time_ms;

  modport source (output valid, kind, pin_level, time_ms, input ready);
  modport sink   (input valid, kind, pin_level, time_ms, output ready);

endinterface

### hw/rtl/pprm_out_if.sv
interface pprm_out_if;
  import pprm_pkg::*;

  logic             valid;
  logic             ready;
  logic [RPM_W-1:0] rpm;

  modport source (output valid, rpm, input ready);
  modport sink   (input valid, rpm, output ready);

endinterface

### hw/rtl/pprm_div.sv
module pprm_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pprm_pkg::div_req_t       req,
  output logic                     done,
  output logic [pprm_pkg::RPM_W-1:0] quotient
);
  import pprm_pkg::*;

  localparam int CNT_W = $clog2(RPM_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [RPM_W-1:0]  quo_r, quo_nxt;
  logic [TIME_W-1:0] dvs_r, dvs_nxt;

  logic [TIME_W:0]   trial;
  logic              fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[RPM_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_nxt = trial[TIME_W-1:0] - dvs_r;
      end else begin
        rem_nxt = trial[TIME_W-1:0];
      end
      quo_nxt = {quo_r[RPM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      // Last quotient bit lands this cycle
      if (cnt_r == CNT_W'(RPM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hw/rtl/pulse_period_rpm_meter_top.sv
// Channel   Direction  Beat payload                  Handshake
// in_ch     in         kind, pin_level, time_ms      valid/ready
// out_ch    out        rpm                           valid/ready
// cfg_*     in         cfg_idx, cfg_wdata            cfg_we, no wait
//
// A poll or an ignored change completes in ST_IDLE; the poll's speed beat is
// registered and shown on the next cycle. A rising edge with a positive
// period takes two passes of 16 steps each through the shared
// restoring divider (pulses to RPM scale, then scale by period).
// rst_n is synchronous: it clears the sequencer, the stamp, the speed and
// the output beat. in_ch.ready drops while a division runs and while a
// speed beat waits without out_ch.ready.
module pulse_period_rpm_meter_top (
  input  logic                             clk,
  input  logic                             rst_n,
  pprm_in_if.sink                          in_ch,
  pprm_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [pprm_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [pprm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pprm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PER_REV,
    ST_RATE
  } state_t;

  state_t            state_r, state_nxt;
  logic [PPR_W-1:0]     ppr_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [RPM_W-1:0]  held_r, held_nxt;
  logic [TIME_W-1:0] delta_r, delta_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [RPM_W-1:0]  out_rpm_r, out_rpm_nxt;

  div_req_t          div_req;
  logic              div_done;
  logic [RPM_W-1:0]  div_quo;

  logic              accept;
  logic [TIME_W-1:0] base;
  logic [TIME_W-1:0] delta;
  logic [TIME_W-1:0] deadline;
  logic [PPR_W-1:0]  ppr_eff;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // First edge measures against itself
  assign base     = (last_r == '0) ? in_ch.time_ms : last_r;
  assign delta    = in_ch.time_ms - base;
  assign deadline = last_r + TIME_W'(timeout_r);
  assign ppr_eff  = (ppr_r == '0) ? PPR_W'(1) : ppr_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    held_nxt      = held_r;
    delta_nxt     = delta_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_rpm_nxt   = out_rpm_r;
    div_req       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.kind == KIND_POLL) begin
            // Drop the speed once the edge has gone stale
            if (deadline < in_ch.time_ms) begin
              held_nxt    = '0;
              last_nxt    = in_ch.time_ms;
              out_rpm_nxt = '0;
            end else begin
              out_rpm_nxt = held_r;
            end
            out_valid_nxt = 1'b1;
          end else if (in_ch.pin_level) begin
            last_nxt = in_ch.time_ms;
            if (delta == '0 || delta[TIME_W-1]) begin
              held_nxt = '0;
            end else begin
              delta_nxt        = delta;
              div_req.start    = 1'b1;
              div_req.dividend = RPM_NUMERATOR;
              div_req.divisor  = TIME_W'(ppr_eff);
              state_nxt        = ST_PER_REV;
            end
          end
        end
      end
      ST_PER_REV: begin
        if (div_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = div_quo;
          div_req.divisor  = delta_r;
          state_nxt        = ST_RATE;
        end
      end
      ST_RATE: begin
        if (div_done) begin
          held_nxt  = div_quo;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
    delta_r   <= delta_nxt;
    out_rpm_r <= out_rpm_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r     <= PPR_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PPR:     ppr_r     <= cfg_wdata[PPR_W-1:0];
        CFG_TIMEOUT: timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.rpm   = out_rpm_r;

  pprm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule
